// ----- rtl/core/cgapp_pkg.sv -----
// Package for the CGA 2bpp pixel packer: screen geometry, store sizing,
// field and code types shared by the interfaces, the shadow store and the top level.
// No dependencies.
package cgapp_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 200;
	localparam int ROW_BYTES     = 80;
	localparam int STORE_DEPTH   = 16000;
	localparam int IDX_W         = $clog2(STORE_DEPTH);

	localparam logic [31:0] PALETTE_RESET = 32'hEA54EA54;
	localparam logic [7:0]  COLOR_MAX     = 8'd15;
	localparam logic [13:0] ODD_BANK      = 14'h2000;
	localparam logic [7:0]  LEFT_PIX_MASK = 8'hC0;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_FLUSH = 1'b1
	} kind_t;

	typedef enum logic {
		SHD_CLEAR = 1'b0,
		SHD_RUN   = 1'b1
	} shd_state_t;

	typedef logic [8:0]       xpos_t;
	typedef logic [7:0]       ypos_t;
	typedef logic [7:0]       color_t;
	typedef logic [13:0]      cga_addr_t;
	typedef logic [7:0]       pix_byte_t;
	typedef logic [IDX_W-1:0] store_idx_t;

	typedef struct packed {
		logic       rd_en;
		store_idx_t rd_idx;
		logic       wr_en;
		store_idx_t wr_idx;
		pix_byte_t  wr_data;
	} shd_req_t;

endpackage

// ----- rtl/core/cgapp_if.sv -----
// Channel interfaces of the CGA 2bpp pixel packer: request, response, config.
// Depends on cgapp_pkg.
interface cgapp_req_if;
	import cgapp_pkg::*;
	logic   valid;
	logic   ready;
	kind_t  kind;
	xpos_t  x;
	ypos_t  y;
	color_t color;
	logic   last_in_run;
	modport source (output valid, kind, x, y, color, last_in_run, input ready);
	modport sink (input valid, kind, x, y, color, last_in_run, output ready);
endinterface

interface cgapp_rsp_if;
	import cgapp_pkg::*;
	logic      valid;
	logic      ready;
	cga_addr_t cga_address;
	pix_byte_t pixel_byte;
	modport source (output valid, cga_address, pixel_byte, input ready);
	modport sink (input valid, cga_address, pixel_byte, output ready);
endinterface

interface cgapp_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/cgapp_shadow.sv -----
// Shadow framebuffer store: single-port-write, registered-read byte memory,
// clearing sweep after reset, and write-to-read forwarding. Depends on cgapp_pkg.
module cgapp_shadow (
	input  logic                clk,
	input  logic                arst_n,
	input  cgapp_pkg::shd_req_t req,
	output cgapp_pkg::pix_byte_t rd_data,
	output logic                busy
);
	import cgapp_pkg::*;

	shd_state_t state_q, state_d;
	store_idx_t clr_idx_q;
	logic       clr_last;

	pix_byte_t  mem [STORE_DEPTH];
	pix_byte_t  mem_q;
	store_idx_t rd_idx_q;

	logic       mem_we;
	store_idx_t mem_wa;
	pix_byte_t  mem_wd;

	logic       lw_v_q;
	store_idx_t lw_idx_q;
	pix_byte_t  lw_data_q;

	assign clr_last = (clr_idx_q == IDX_W'(STORE_DEPTH - 1));

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		case (state_q)
			SHD_CLEAR: begin
				busy = 1'b1;
				if (clr_last) begin
					state_d = SHD_RUN;
				end
			end
			SHD_RUN: begin
				state_d = SHD_RUN;
			end
			default: begin
				state_d = SHD_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SHD_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (busy && !clr_last) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	assign mem_we = busy || req.wr_en;
	assign mem_wa = busy ? clr_idx_q : req.wr_idx;
	assign mem_wd = busy ? '0 : req.wr_data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (req.rd_en) begin
			mem_q    <= mem[req.rd_idx];
			rd_idx_q <= req.rd_idx;
		end
	end

	// newest write wins over the memory's read-before-write data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_v_q <= 1'b0;
		end else if (req.wr_en) begin
			lw_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			lw_idx_q  <= req.wr_idx;
			lw_data_q <= req.wr_data;
		end
	end

	assign rd_data = (lw_v_q && (lw_idx_q == rd_idx_q)) ? lw_data_q : mem_q;

	a_no_access_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SHD_CLEAR) |-> (!req.rd_en && !req.wr_en))
		else $error("shadow access during clear sweep");

	a_clear_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		clr_idx_q <= IDX_W'(STORE_DEPTH - 1))
		else $error("clear index beyond store");

	a_forward_same_edge: assert property (@(posedge clk) disable iff (!arst_n)
		($past(req.wr_en) && $past(req.rd_en) && ($past(req.wr_idx) == $past(req.rd_idx)))
		|-> (rd_data == $past(req.wr_data)))
		else $error("read missed a write to the same byte");

endmodule

// ----- rtl/core/cga_2bpp_pixel_packer.sv -----
// Top level of the CGA 2bpp pixel packer: palette register, address and
// colour mapping, read-modify-write stage and response register.
// Depends on cgapp_pkg, cgapp_if.sv and cgapp_shadow.
//
// Usage: req carries pixel writes (kind 0) and flush reads (kind 1); rsp
// returns one transaction per flush read with its interlaced CGA address and
// packed byte; cfg writes the 32-bit palette (taken whenever valid).
// Throughput is one request per cycle unless the clear sweep runs or a flush
// waits (see below): the shadow memory is read at accept, the byte is merged
// in the merge stage and written back, with the last write forwarded to a
// read of the same byte. A flush response moves from the merge stage into the
// output register once that register is free, which raises rsp.valid.
// After reset the palette returns to its default and the shadow store is
// zeroed by a sweep over all 16000 bytes, one byte a cycle; req.ready stays low
// during the sweep while cfg writes are still taken.
// When rsp stalls, a flush waits in the merge stage and req.ready drops
// until the output register frees up; pixel writes never wait.
module cga_2bpp_pixel_packer (
	input logic        clk,
	input logic        arst_n,
	cgapp_req_if.sink  req,
	cgapp_rsp_if.source rsp,
	cgapp_cfg_if.sink  cfg
);
	import cgapp_pkg::*;

	logic [31:0] palette_q;

	logic       acc;
	logic       busy;
	logic       s1_free;
	logic       out_load;
	xpos_t      x_c;
	ypos_t      y_c;
	logic       on_screen;
	logic [14:0] row_off;
	store_idx_t idx_c;
	logic [12:0] half_off;
	cga_addr_t  cga_c;
	logic [1:0] col_c;

	logic       v_s1;
	kind_t      kind_s1;
	logic       wr_s1;
	store_idx_t idx_s1;
	logic [1:0] pos_s1;
	logic [1:0] col_s1;
	cga_addr_t  cga_s1;

	pix_byte_t  base_byte;
	pix_byte_t  clr_mask;
	pix_byte_t  new_bits;
	shd_req_t   shd_req;

	logic       out_v_q;
	cga_addr_t  out_addr_q;
	pix_byte_t  out_byte_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q <= PALETTE_RESET;
		end else if (cfg.valid) begin
			palette_q <= cfg.data;
		end
	end

	// clipping leaves on-screen coordinates unchanged
	assign x_c = (req.x >= 9'(SCREEN_WIDTH)) ? 9'(SCREEN_WIDTH - 1) : req.x;
	assign y_c = (req.y >= 8'(SCREEN_HEIGHT)) ? 8'(SCREEN_HEIGHT - 1) : req.y;
	assign on_screen = (req.x < 9'(SCREEN_WIDTH)) && (req.y < 8'(SCREEN_HEIGHT));

	// 80*y = 64*y + 16*y
	assign row_off  = {1'b0, y_c, 6'b0} + {3'b0, y_c, 4'b0};
	assign idx_c    = IDX_W'(row_off + {8'b0, x_c[8:2]});
	assign half_off = {y_c[7:1], 6'b0} + {2'b0, y_c[7:1], 4'b0} + {6'b0, x_c[8:2]};
	assign cga_c    = (y_c[0] ? ODD_BANK : '0) | {1'b0, half_off};

	assign col_c = (req.color > COLOR_MAX) ? 2'b00 : palette_q[{req.color[3:0], 1'b0} +: 2];

	assign s1_free  = !v_s1 || (kind_s1 == KIND_WRITE) || !out_v_q || rsp.ready;
	assign req.ready = !busy && s1_free;
	assign acc      = req.valid && req.ready;
	assign out_load = v_s1 && (kind_s1 == KIND_FLUSH) && (!out_v_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (s1_free) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1 <= req.kind;
			wr_s1   <= (req.kind == KIND_WRITE) && on_screen;
			idx_s1  <= idx_c;
			pos_s1  <= req.x[1:0];
			col_s1  <= col_c;
			cga_s1  <= cga_c;
		end
	end

	assign clr_mask = LEFT_PIX_MASK >> {pos_s1, 1'b0};
	assign new_bits = {col_s1, 6'b0} >> {pos_s1, 1'b0};

	always_comb begin
		shd_req.rd_en   = acc;
		shd_req.rd_idx  = idx_c;
		shd_req.wr_en   = v_s1 && (kind_s1 == KIND_WRITE) && wr_s1;
		shd_req.wr_idx  = idx_s1;
		shd_req.wr_data = (base_byte & ~clr_mask) | new_bits;
	end

	cgapp_shadow u_shadow (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (shd_req),
		.rd_data (base_byte),
		.busy    (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_addr_q <= cga_s1;
			out_byte_q <= base_byte;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.cga_address = out_addr_q;
	assign rsp.pixel_byte  = out_byte_q;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=>
		(rsp.valid && $stable(rsp.cga_address) && $stable(rsp.pixel_byte)))
		else $error("response changed while stalled");

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !req.ready)
		else $error("request taken during clear sweep");

	a_flush_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (kind_s1 == KIND_FLUSH) && !out_load) |=>
		(v_s1 && (kind_s1 == KIND_FLUSH) && $stable(cga_s1)))
		else $error("waiting flush lost from merge stage");

endmodule

// ----- test/cga_2bpp_pixel_packer_checker.sv -----
// Checker for the CGA 2bpp pixel packer: keeps its own shadow framebuffer and palette,
// predicts each flush-read response and compares it with what the rsp channel returns.
// Depends on cgapp_pkg and the channel interfaces in cgapp_if.sv.
module cga_2bpp_pixel_packer_checker (
	input logic         clk,
	input logic         arst_n,
	cgapp_req_if        req,
	cgapp_rsp_if        rsp,
	cgapp_cfg_if        cfg,
	output int unsigned open_reads,
	output int unsigned mismatches
);
	import cgapp_pkg::*;

	typedef struct packed {
		cga_addr_t cga_address;
		pix_byte_t pixel_byte;
	} flush_byte_t;

	pix_byte_t   shadow [STORE_DEPTH];
	logic [31:0] palette;
	flush_byte_t flush_q [$];

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : predict
		int unsigned px;
		int unsigned py;
		int unsigned idx;
		int unsigned sh;
		logic [1:0]  cga_col;
		flush_byte_t want;
		if (!arst_n) begin
			palette = PALETTE_RESET;
			foreach (shadow[i]) shadow[i] = '0;
			flush_q.delete();
			mismatches = 0;
			open_reads <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (flush_q.size() == 0) begin
					flag_mismatch("response with no flush read pending",
						{rsp.cga_address, rsp.pixel_byte}, 0);
				end else begin
					want = flush_q.pop_front();
					if (rsp.cga_address !== want.cga_address)
						flag_mismatch("cga_address", rsp.cga_address, want.cga_address);
					if (rsp.pixel_byte !== want.pixel_byte)
						flag_mismatch("pixel_byte", rsp.pixel_byte, want.pixel_byte);
				end
			end
			if (req.valid && req.ready) begin
				px = req.x;
				py = req.y;
				if (req.kind == KIND_WRITE) begin
					// off-screen pixel writes are dropped
					if (px < SCREEN_WIDTH && py < SCREEN_HEIGHT) begin
						cga_col = (req.color > COLOR_MAX) ? 2'b00 :
							2'(palette >> (2 * int'(req.color)));
						idx = ROW_BYTES * py + px / 4;
						sh = 2 * (px % 4);
						shadow[idx] = (shadow[idx] & ~(LEFT_PIX_MASK >> sh)) |
							(pix_byte_t'(cga_col) << (6 - sh));
					end
				end else begin
					if (px >= SCREEN_WIDTH) px = SCREEN_WIDTH - 1;
					if (py >= SCREEN_HEIGHT) py = SCREEN_HEIGHT - 1;
					want.cga_address = cga_addr_t'(((py % 2 == 1) ? int'(ODD_BANK) : 0) +
						ROW_BYTES * (py / 2) + px / 4);
					want.pixel_byte = shadow[ROW_BYTES * py + px / 4];
					flush_q.push_back(want);
				end
			end
			if (cfg.valid && cfg.ready) palette = cfg.data;
			open_reads <= flush_q.size();
		end
	end

endmodule

// ----- test/cga_2bpp_pixel_packer_test.sv -----
// Testbench top for the CGA 2bpp pixel packer: drives pixel runs, flush reads and
// palette writes with random bursts and response stalls; the checker does the scoring.
// Depends on cgapp_pkg, cgapp_if.sv, the block and cga_2bpp_pixel_packer_checker.
module cga_2bpp_pixel_packer_test;
	import cgapp_pkg::*;

	localparam int unsigned IDLE_LIMIT = 60000;
	localparam int unsigned PHASES     = 6;
	localparam int unsigned PHASE_ITEMS = 165;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned open_reads;
	int unsigned mismatches;
	int unsigned burst_left = 0;
	int unsigned sink_mode = 0;
	int unsigned sink_left = 0;
	int unsigned idle_cycles = 0;

	cgapp_req_if req ();
	cgapp_rsp_if rsp ();
	cgapp_cfg_if cfg ();

	cga_2bpp_pixel_packer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	cga_2bpp_pixel_packer_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.open_reads (open_reads),
		.mismatches (mismatches)
	);

	always #5 clk = ~clk;

	// receiver: changes stall mode every so often
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode = $urandom_range(0, 3);
			sink_left = $urandom_range(16, 200);
		end else begin
			sink_left--;
		end
		case (sink_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(0, 1) == 0);
			2: rsp.ready <= ($urandom_range(0, 7) == 0);
			default: rsp.ready <= (sink_left % 8 != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("cga_2bpp_pixel_packer_test NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input kind_t k, input int unsigned px, input int unsigned py,
			input int unsigned pc, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid       <= 1'b1;
		req.kind        <= k;
		req.x           <= xpos_t'(px);
		req.y           <= ypos_t'(py);
		req.color       <= color_t'(pc);
		req.last_in_run <= last;
		do @(posedge clk); while (req.ready !== 1'b1);
	endtask

	task automatic wait_quiet();
		req.valid <= 1'b0;
		do @(posedge clk); while (open_reads != 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic int unsigned pick_color();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(16, 255) : $urandom_range(0, 15);
	endfunction

	initial begin
		int unsigned sent;
		int unsigned x0;
		int unsigned y0;
		int unsigned len;
		int unsigned b;
		logic [31:0] pal;
		req.valid = 1'b0;
		req.kind = KIND_WRITE;
		req.x = '0;
		req.y = '0;
		req.color = '0;
		req.last_in_run = 1'b0;
		rsp.ready = 1'b1;
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// byte packing, colors above fifteen, screen corners, clipping, odd rows
		send_item(KIND_WRITE, 0, 0, 0, 1'b0);
		send_item(KIND_WRITE, 1, 0, 15, 1'b0);
		send_item(KIND_WRITE, 2, 0, 9, 1'b0);
		send_item(KIND_WRITE, 3, 0, 255, 1'b1);
		send_item(KIND_FLUSH, 0, 0, 0, 1'b0);
		send_item(KIND_WRITE, 2, 0, 16, 1'b0);
		send_item(KIND_FLUSH, 3, 0, 255, 1'b1);
		send_item(KIND_WRITE, 319, 199, 5, 1'b0);
		send_item(KIND_WRITE, 316, 199, 10, 1'b1);
		send_item(KIND_FLUSH, 319, 199, 0, 1'b0);
		send_item(KIND_WRITE, 320, 0, 3, 1'b0);
		send_item(KIND_WRITE, 0, 200, 3, 1'b0);
		send_item(KIND_WRITE, 511, 255, 15, 1'b1);
		send_item(KIND_FLUSH, 320, 0, 0, 1'b0);
		send_item(KIND_FLUSH, 511, 255, 0, 1'b0);
		send_item(KIND_FLUSH, 0, 255, 0, 1'b0);
		send_item(KIND_WRITE, 5, 1, 7, 1'b0);
		send_item(KIND_FLUSH, 4, 1, 0, 1'b0);
		send_item(KIND_WRITE, 170, 170, 170, 1'b0);
		send_item(KIND_WRITE, 341, 85, 12, 1'b0);
		send_item(KIND_WRITE, 9, 2, 3, 1'b0);
		send_item(KIND_FLUSH, 8, 2, 0, 1'b1);
		send_item(KIND_FLUSH, 170, 170, 0, 1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				case (ph)
					1: pal = 32'h0000_0000;
					2: pal = 32'hFFFF_FFFF;
					3: pal = 32'hE4E4_E4E4;
					default: pal = $urandom();
				endcase
				wait_quiet();
				cfg.valid <= 1'b1;
				cfg.data  <= pal;
				do @(posedge clk); while (cfg.ready !== 1'b1);
				cfg.valid <= 1'b0;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 7) begin
					// a horizontal run, then flush the bytes it touched
					y0 = ($urandom_range(0, 3) == 0) ?
						$urandom_range(SCREEN_HEIGHT - 4, SCREEN_HEIGHT - 1) : $urandom_range(0, 7);
					x0 = ($urandom_range(0, 3) == 0) ?
						$urandom_range(SCREEN_WIDTH - 16, SCREEN_WIDTH - 1) : $urandom_range(0, 31);
					len = $urandom_range(1, 12);
					for (int i = 0; i < len; i++)
						send_item(KIND_WRITE, x0 + i, y0, pick_color(), i == len - 1);
					sent += len;
					for (b = x0 & ~32'd3; b < x0 + len; b += 4) begin
						send_item(KIND_FLUSH, b + $urandom_range(0, 3), y0, $urandom_range(0, 255),
							1'($urandom_range(0, 1)));
						sent++;
					end
				end else begin
					send_item(kind_t'($urandom_range(0, 1)), $urandom_range(0, 511),
						$urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom_range(0, 1)));
					sent++;
				end
			end
		end

		wait_quiet();
		if (mismatches == 0)
			$display("cga_2bpp_pixel_packer_test OK");
		else
			$display("cga_2bpp_pixel_packer_test NOT OK");
		$finish;
	end

endmodule
